[rtl/res_pkg.sv]
// Shared types and constants for the record exchange sort block.
// Holds the record and beat structs, the store sizing and the key compare mask.
// No dependencies.
package res_pkg;

  // Store sizing.
  localparam int RecCap   = 32;
  localparam int AddrW    = $clog2(RecCap);
  localparam int CntW     = $clog2(RecCap + 1);

  // Key layout: four 64-bit words, first byte most significant.
  localparam int WordW    = 64;
  localparam int KeyW     = 4 * WordW;
  localparam int KeyBytes = 30;
  localparam int KeyLanes = KeyW / 8;

  // One stored record.
  typedef struct packed {
    logic [WordW-1:0] key_word0;
    logic [WordW-1:0] key_word1;
    logic [WordW-1:0] key_word2;
    logic [WordW-1:0] key_word3;
    logic [WordW-1:0] payload;
  } rec_t;

  // Input beat.
  typedef struct packed {
    logic [WordW-1:0] key_word0;
    logic [WordW-1:0] key_word1;
    logic [WordW-1:0] key_word2;
    logic [WordW-1:0] key_word3;
    logic [WordW-1:0] payload;
    logic             last_in;
  } res_in_t;

  // Output beat.
  typedef struct packed {
    logic [WordW-1:0] out_key_word0;
    logic [WordW-1:0] out_key_word1;
    logic [WordW-1:0] out_key_word2;
    logic [WordW-1:0] out_key_word3;
    logic [WordW-1:0] out_payload;
    logic             last_out;
    logic             overflowed;
  } res_out_t;

  // Mask over the concatenated key that keeps only the bytes that take part
  // in the comparison; byte 0 sits in the top bits.
  function automatic logic [KeyW-1:0] key_mask();
    logic [KeyW-1:0] m;
    m = '0;
    for (int b = 0; b < KeyLanes; b++) begin
      if (b < KeyBytes) begin
        m[KeyW-1-8*b -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

[rtl/res_store.sv]
// Record store: one write port and one read port with registered read data.
// Depends on res_pkg for the record type and address width.
module res_store
  import res_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  rec_t             wdata,
  input  logic [AddrW-1:0] raddr,
  output rec_t             rdata
);

  rec_t mem [RecCap];
  rec_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/res_cmp.sv]
// Key compare unit: true when key a is greater than key b in unsigned byte order.
// Depends on res_pkg for the record type and the compare mask.
module res_cmp
  import res_pkg::*;
(
  input  rec_t a,
  input  rec_t b,
  output logic a_gt
);

  localparam logic [KeyW-1:0] KeyMask = key_mask();

  logic [KeyW-1:0] ka;
  logic [KeyW-1:0] kb;

  // Byte 0 is most significant, so one wide compare gives the byte order.
  assign ka   = {a.key_word0, a.key_word1, a.key_word2, a.key_word3} & KeyMask;
  assign kb   = {b.key_word0, b.key_word1, b.key_word2, b.key_word3} & KeyMask;
  assign a_gt = ka > kb;

endmodule

[rtl/record_exchange_sort_top.sv]
// Record exchange sort top level: loads records, sorts them on the last one, streams them out.
// Depends on res_pkg, res_store and res_cmp.
//
// Records are taken one per cycle while the block is idle; up to 32 are held
// and further ones are dropped, which sets overflowed on every beat of the run.
// The beat marked last closes the set, after which in_stall stays high until
// the last sorted beat has been taken. The sort is an exchange sort in which
// every compare goes through the one key compare unit and every record is
// fetched through the single read port of the store. Output primes the read
// in ST_ORD, then each beat passes through ST_OLD and ST_OWAIT, and the next
// beat is not loaded into the output before this one has been taken.
module record_exchange_sort_top
  import res_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  res_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output res_out_t out_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CURI  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_WRI   = 3'd3;
  localparam logic [2:0] ST_ORD   = 3'd4;
  localparam logic [2:0] ST_OLD   = 3'd5;
  localparam logic [2:0] ST_OWAIT = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [AddrW-1:0] i_r, i_nxt;
  logic [AddrW-1:0] j_r, j_nxt;
  rec_t             cur_r, cur_nxt;
  res_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             we;
  logic [AddrW-1:0] waddr;
  rec_t             wdata;
  logic [AddrW-1:0] raddr;
  rec_t             rdata;
  logic             cur_gt;
  logic [CntW-1:0]  count_m1;

  // Record store and the shared compare unit.
  res_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  res_cmp u_cmp (
    .a    (cur_r),
    .b    (rdata),
    .a_gt (cur_gt)
  );

  assign count_m1 = count_r - CntW'(1);

  // Sequencer: load, exchange sort with the current record i held in cur_r,
  // then stream the store out in order.
  always_comb begin
    logic [CntW-1:0] n_new;
    n_new         = count_r;
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = i_r;
    wdata         = cur_r;
    raddr         = '0;
    case (state_r)
      ST_IDLE: begin
        raddr = '0;
        if (in_valid) begin
          if (count_r < CntW'(RecCap)) begin
            we              = 1'b1;
            waddr           = count_r[AddrW-1:0];
            wdata.key_word0 = in_data.key_word0;
            wdata.key_word1 = in_data.key_word1;
            wdata.key_word2 = in_data.key_word2;
            wdata.key_word3 = in_data.key_word3;
            wdata.payload   = in_data.payload;
            n_new           = count_r + CntW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          count_nxt = n_new;
          if (in_data.last_in) begin
            i_nxt = '0;
            if (n_new >= CntW'(2)) begin
              state_nxt = ST_CURI;
            end else begin
              state_nxt = ST_ORD;
            end
          end
        end
      end
      ST_CURI: begin
        // Record i arrives; start the inner pass at i + 1.
        cur_nxt   = rdata;
        raddr     = i_r + AddrW'(1);
        j_nxt     = i_r + AddrW'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Compare the held record with record j; swap by writing it back.
        raddr = j_r + AddrW'(1);
        if (cur_gt) begin
          we      = 1'b1;
          waddr   = j_r;
          wdata   = cur_r;
          cur_nxt = rdata;
        end
        if (CntW'(j_r) == count_m1) begin
          state_nxt = ST_WRI;
        end else begin
          j_nxt = j_r + AddrW'(1);
        end
      end
      ST_WRI: begin
        // Settle position i and fetch the next outer record.
        we    = 1'b1;
        waddr = i_r;
        wdata = cur_r;
        raddr = i_r + AddrW'(1);
        if (CntW'(i_r) + CntW'(2) < count_r) begin
          i_nxt     = i_r + AddrW'(1);
          state_nxt = ST_CURI;
        end else begin
          i_nxt     = '0;
          state_nxt = ST_ORD;
        end
      end
      ST_ORD: begin
        raddr     = i_r;
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        out_nxt.out_key_word0 = rdata.key_word0;
        out_nxt.out_key_word1 = rdata.key_word1;
        out_nxt.out_key_word2 = rdata.key_word2;
        out_nxt.out_key_word3 = rdata.key_word3;
        out_nxt.out_payload   = rdata.payload;
        out_nxt.last_out      = (CntW'(i_r) == count_m1);
        out_nxt.overflowed    = drop_r;
        out_valid_nxt         = 1'b1;
        state_nxt             = ST_OWAIT;
      end
      ST_OWAIT: begin
        // Prefetch the next record so it is ready once this beat is taken.
        raddr = i_r + AddrW'(1);
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_out) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            i_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + AddrW'(1);
            state_nxt = ST_OLD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      drop_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result beat is only shown while waiting for it to be taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_OWAIT)
    else $error("output valid outside the output wait state");

  // The inner index always runs ahead of the outer one.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> j_r > i_r)
    else $error("inner index not above outer index");

  // The fill count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(RecCap))
    else $error("record count above capacity");

  // Records are only dropped once the store is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> count_r == CntW'(RecCap))
    else $error("drop flag set with room left");

  // Taking the final beat returns the block to an empty idle state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && out_r.last_out |=>
      state_r == ST_IDLE && count_r == '0 && !drop_r)
    else $error("block not empty after final beat");

endmodule

[bench/tb.sv]
// Self-checking bench for record_exchange_sort_top: record sets in, sorted beats out.
// Depends on res_pkg and the record_exchange_sort_top RTL; the sort is predicted locally.
module tb;
  import res_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  res_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  res_out_t out_data;

  record_exchange_sort_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // One row of the directed stimulus; typed rows carry their own expected beat.
  typedef struct {
    res_in_t  beat;
    bit       typed;
    res_out_t want;
  } dir_row_t;

  localparam logic [WordW-1:0] Ones = '1;
  localparam int RandomRecords = 260;

  // Local copy of the record store and the sorted beats still owed by the block.
  rec_t     held[RecCap];
  int       held_n;
  bit       dropped;
  res_out_t run_beats[$];
  res_out_t sorted_due[$];
  dir_row_t dir_rows[$];

  int errors;
  int records_sent;
  int sets_sent;
  int full_sets;
  int beats_checked;
  int hold_left;
  bit burst;

  // Clock: period 8.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic res_in_t mk_in(logic [WordW-1:0] w0, logic [WordW-1:0] w1,
                                    logic [WordW-1:0] w2, logic [WordW-1:0] w3,
                                    logic [WordW-1:0] pl, logic last);
    res_in_t r;
    r.key_word0 = w0;
    r.key_word1 = w1;
    r.key_word2 = w2;
    r.key_word3 = w3;
    r.payload   = pl;
    r.last_in   = last;
    return r;
  endfunction

  function automatic res_out_t mk_out(logic [WordW-1:0] w0, logic [WordW-1:0] w1,
                                      logic [WordW-1:0] w2, logic [WordW-1:0] w3,
                                      logic [WordW-1:0] pl, logic last, logic ovf);
    res_out_t r;
    r.out_key_word0 = w0;
    r.out_key_word1 = w1;
    r.out_key_word2 = w2;
    r.out_key_word3 = w3;
    r.out_payload   = pl;
    r.last_out      = last;
    r.overflowed    = ovf;
    return r;
  endfunction

  // True when key a sorts after key b; bytes past the compared length do not count.
  function automatic bit key_after(rec_t a, rec_t b);
    logic [KeyW-1:0] ka;
    logic [KeyW-1:0] kb;
    ka = {a.key_word0, a.key_word1, a.key_word2, a.key_word3};
    kb = {b.key_word0, b.key_word1, b.key_word2, b.key_word3};
    return (ka >> (KeyW - 8 * KeyBytes)) > (kb >> (KeyW - 8 * KeyBytes));
  endfunction

  // Store or drop one accepted record; on the last one, exchange sort the set
  // and leave the sorted beats in run_beats.
  function automatic void absorb_record(res_in_t b);
    rec_t t;
    run_beats.delete();
    if (held_n < RecCap) begin
      held[held_n].key_word0 = b.key_word0;
      held[held_n].key_word1 = b.key_word1;
      held[held_n].key_word2 = b.key_word2;
      held[held_n].key_word3 = b.key_word3;
      held[held_n].payload   = b.payload;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (!b.last_in) return;
    for (int i = 0; i + 1 < held_n; i++) begin
      for (int j = i; j < held_n; j++) begin
        if (key_after(held[i], held[j])) begin
          t       = held[i];
          held[i] = held[j];
          held[j] = t;
        end
      end
    end
    for (int i = 0; i < held_n; i++) begin
      run_beats.push_back(mk_out(held[i].key_word0, held[i].key_word1, held[i].key_word2,
                                 held[i].key_word3, held[i].payload, i == held_n - 1,
                                 dropped));
    end
    held_n  = 0;
    dropped = 1'b0;
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Byte values that sit on the edges of the unsigned order.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7f;
      3: return 8'h80;
      4: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, int beat_no, logic [WordW-1:0] got,
                                 logic [WordW-1:0] want);
    errors++;
    if (errors <= 30) begin
      $display("beat %0d: %s got %h, want %h", beat_no, what, got, want);
    end
  endtask

  // Present one record after a random gap and hold it until the block takes it.
  task automatic send_beat(res_in_t b, bit typed, res_out_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    absorb_record(b);
    if (typed) begin
      sorted_due.push_back(want);
    end else begin
      foreach (run_beats[i]) sorted_due.push_back(run_beats[i]);
    end
    records_sent++;
    @(negedge clk);
  endtask

  // One random set: unrelated keys, keys that differ from one common base in one
  // or two bytes, or such keys mixed with exact and near duplicates.
  task automatic send_set(int n);
    logic [KeyW-1:0] base;
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] seen[$];
    int              style;
    int              pos;
    res_in_t         b;
    res_out_t        none;
    style = $urandom_range(0, 2);
    burst = ($urandom_range(0, 3) == 0);
    base  = rand_key();
    none  = '0;
    for (int r = 0; r < n; r++) begin
      if (style == 0) begin
        k = rand_key();
      end else begin
        k = base;
        repeat ($urandom_range(1, 2)) begin
          pos = $urandom_range(0, KeyLanes - 1);
          k[KeyW-1-8*pos -: 8] = pick_byte();
        end
      end
      if (style == 2 && seen.size() > 0 && $urandom_range(0, 3) == 0) begin
        k = seen[$urandom_range(0, seen.size() - 1)];
        if ($urandom_range(0, 1) == 1) k[15:0] = 16'($urandom);
      end
      seen.push_back(k);
      b = mk_in(k[255:192], k[191:128], k[127:64], k[63:0], {$urandom, $urandom}, r == n - 1);
      send_beat(b, 1'b0, none);
    end
    sets_sent++;
    if (n > RecCap) full_sets++;
  endtask

  // Directed sets: extremes, ties hidden in the uncompared tail bytes, zero
  // bytes inside keys and the unsigned byte order.
  task automatic load_directed();
    res_out_t none;
    none = '0;
    dir_rows.push_back('{mk_in('0, '0, '0, '0, '0, 1'b1), 1'b1,
                         mk_out('0, '0, '0, '0, '0, 1'b1, 1'b0)});
    dir_rows.push_back('{mk_in(Ones, Ones, Ones, Ones, Ones, 1'b1), 1'b1,
                         mk_out(Ones, Ones, Ones, Ones, Ones, 1'b1, 1'b0)});
    dir_rows.push_back('{mk_in(Ones, Ones, Ones, Ones, 64'd1, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk_in('0, '0, '0, '0, 64'd2, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h8000_0000_0000_0000, '0, '0, '0, 64'd3, 1'b1), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h11, 64'h22, 64'h33, 64'h1122_3344_5566_0000, 64'd4, 1'b0),
                         1'b0, none});
    dir_rows.push_back('{mk_in(64'h11, 64'h22, 64'h33, 64'h1122_3344_5566_ffff, 64'd5, 1'b0),
                         1'b0, none});
    dir_rows.push_back('{mk_in(64'h11, 64'h22, 64'h33, 64'h1122_3344_5565_ffff, 64'd6, 1'b0),
                         1'b0, none});
    dir_rows.push_back('{mk_in(64'h11, 64'h22, 64'h33, 64'h1122_3344_5566_abcd, 64'd7, 1'b1),
                         1'b0, none});
    dir_rows.push_back('{mk_in(64'h4100_4200_0000_0000, '0, '0, '0, 64'd8, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h4100_0000_0000_0000, '0, '0, '0, 64'd9, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h4100_4100_0000_0000, '0, '0, '0, 64'd10, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h4100_0000_0000_0000, '0, '0, 64'h0000_0100_0000_0000,
                               64'd11, 1'b1), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h8000_0000_0000_0000, '0, '0, '0, 64'd12, 1'b0), 1'b0, none});
    dir_rows.push_back('{mk_in(64'h7fff_ffff_ffff_ffff, Ones, Ones, Ones, 64'd13, 1'b1),
                         1'b0, none});
    dir_rows.push_back('{mk_in(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                               64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00,
                               64'h5a5a_a5a5_0f0f_f0f0, 1'b1), 1'b1,
                         mk_out(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                                64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00,
                                64'h5a5a_a5a5_0f0f_f0f0, 1'b1, 1'b0)});
  endtask

  // Result side: stall while the wait drawn after the last beat taken runs down.
  always @(negedge clk) begin
    out_stall <= (hold_left > 0);
  end

  // Compare each sorted beat with the oldest expected one, then draw the next wait.
  always @(posedge clk) begin
    res_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        report_mismatch("unexpected beat, key_word0", beats_checked,
                        out_data.out_key_word0, '0);
      end else begin
        want = sorted_due.pop_front();
        if (out_data.out_key_word0 !== want.out_key_word0)
          report_mismatch("key_word0", beats_checked, out_data.out_key_word0, want.out_key_word0);
        if (out_data.out_key_word1 !== want.out_key_word1)
          report_mismatch("key_word1", beats_checked, out_data.out_key_word1, want.out_key_word1);
        if (out_data.out_key_word2 !== want.out_key_word2)
          report_mismatch("key_word2", beats_checked, out_data.out_key_word2, want.out_key_word2);
        if (out_data.out_key_word3 !== want.out_key_word3)
          report_mismatch("key_word3", beats_checked, out_data.out_key_word3, want.out_key_word3);
        if (out_data.out_payload !== want.out_payload)
          report_mismatch("payload", beats_checked, out_data.out_payload, want.out_payload);
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", beats_checked, 64'(out_data.last_out), 64'(want.last_out));
        if (out_data.overflowed !== want.overflowed)
          report_mismatch("overflowed", beats_checked, 64'(out_data.overflowed),
                          64'(want.overflowed));
      end
      beats_checked++;
      hold_left = burst ? 0 : $urandom_range(0, 9);
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Main sequence: reset, directed sets, random sets, drain.
  initial begin
    int random_start;
    int r;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    held_n        = 0;
    dropped       = 1'b0;
    records_sent  = 0;
    sets_sent     = 0;
    full_sets     = 0;
    burst         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_directed();
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    end

    // Mostly small sets, some medium, a few just below, at or past capacity.
    random_start = records_sent;
    while (records_sent - random_start < RandomRecords) begin
      r = $urandom_range(0, 9);
      if (r < 7) send_set($urandom_range(1, 8));
      else if (r < 9) send_set($urandom_range(9, 24));
      else send_set($urandom_range(30, 36));
    end
    in_valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("%0d records in %0d random sets plus directed sets, %0d sets past capacity",
             records_sent, sets_sent, full_sets);
    $display("%0d sorted beats checked, %0d mismatches", beats_checked, errors);
    if (errors == 0 && sorted_due.size() == 0) begin
      $display("record_exchange_sort_top: match");
    end else begin
      $display("record_exchange_sort_top: mismatch");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("record_exchange_sort_top: mismatch");
    $finish;
  end

endmodule

[sim.f]
rtl/res_pkg.sv
rtl/res_store.sv
rtl/res_cmp.sv
rtl/record_exchange_sort_top.sv
bench/tb.sv
